// ===== rtl/asesq_pkg.sv =====
// Shared types, register codes and time-scaling helpers for the step-excitation sequencer.
package asesq_pkg;

	localparam int MaskW = 16;
	localparam int TimeW = 32;
	localparam int DriveW = 7;
	localparam int IdxW = 5;
	localparam int CfgW = 16;

	typedef enum logic [2:0] {
		REG_PROBER_TYPE = 3'd0,
		REG_ACT_MASK    = 3'd1,
		REG_PRE_DELAY   = 3'd2,
		REG_POST_DELAY  = 3'd3,
		REG_STEP_PERIOD = 3'd4,
		REG_STEP_AMP    = 3'd5,
		REG_STEPPED     = 3'd6,
		REG_ACT_COUNT   = 3'd7
	} reg_idx_t;

	localparam logic [1:0] PT_STEP  = 2'd0;
	localparam logic [1:0] PT_ORTHO = 2'd2;

	localparam logic [TimeW-1:0] SafetyUs = 32'd100000;
	localparam logic [TimeW-1:0] OrthoUs = 32'd700000;
	localparam logic [DriveW-1:0] AmpMax = 7'd100;
	localparam logic [DriveW-1:0] ServoTrig = 7'd40;

	localparam logic [1:0] RstProberType = 2'd0;
	localparam logic [MaskW-1:0] RstMask = 16'hFFFF;
	localparam logic [15:0] RstPreMs = 16'd100;
	localparam logic [15:0] RstPostMs = 16'd0;
	localparam logic [15:0] RstStepMs = 16'd100;
	localparam logic [DriveW-1:0] RstAmp = 7'd35;
	localparam logic [IdxW-1:0] RstStepped = 5'd4;
	localparam logic [IdxW-1:0] RstActCount = 5'd4;

	typedef struct packed {
		logic [1:0]        prober_type;
		logic [MaskW-1:0]  mask;
		logic [TimeW-1:0]  pre_us;
		logic [TimeW-1:0]  post_us;
		logic [TimeW-1:0]  step_us;
		logic [TimeW-1:0]  span_us;
		logic [TimeW-1:0]  base_us;
		logic [DriveW-1:0] amp;
		logic [IdxW-1:0]   stepped;
		logic [IdxW-1:0]   act_count;
	} cfg_t;

	typedef struct packed {
		logic              all_done;
		logic              generation_done;
		logic              generating;
		logic [DriveW-1:0] drive_3;
		logic [DriveW-1:0] drive_2;
		logic [DriveW-1:0] drive_1;
		logic [DriveW-1:0] drive_0;
	} result_t;

	function automatic logic [TimeW-1:0] ms_to_us(input logic [15:0] ms);
		logic [25:0] p;
		p = {10'b0, ms} * 26'd1000;
		return {6'b0, p};
	endfunction

	function automatic logic [TimeW-1:0] base_us(input logic [15:0] pre_ms,
		input logic [15:0] post_ms);
		logic [16:0] s;
		logic [26:0] p;
		s = {1'b0, pre_ms} + {1'b0, post_ms};
		p = {10'b0, s} * 27'd1000;
		return SafetyUs + {5'b0, p};
	endfunction

	function automatic logic [TimeW-1:0] span_us(input logic [15:0] step_ms,
		input logic [IdxW-1:0] n);
		logic [20:0] a;
		logic [30:0] p;
		a = {5'b0, step_ms} * {16'b0, n};
		p = {10'b0, a} * 31'd1000;
		return {1'b0, p};
	endfunction

endpackage

// ===== rtl/asesq_cfg.sv =====
// Configuration registers and their precomputed microsecond spans.
module asesq_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_idx,
	input  logic [asesq_pkg::CfgW-1:0]   cfg_wdata,
	output asesq_pkg::cfg_t              cfg
);

	logic [1:0]                     prober_type_q;
	logic [asesq_pkg::MaskW-1:0]    mask_q;
	logic [15:0]                    pre_ms_q;
	logic [15:0]                    post_ms_q;
	logic [15:0]                    step_ms_q;
	logic [asesq_pkg::DriveW-1:0]   amp_q;
	logic [asesq_pkg::IdxW-1:0]     stepped_q;
	logic [asesq_pkg::IdxW-1:0]     act_count_q;
	logic [asesq_pkg::TimeW-1:0]    pre_us_q;
	logic [asesq_pkg::TimeW-1:0]    post_us_q;
	logic [asesq_pkg::TimeW-1:0]    step_us_q;
	logic [asesq_pkg::TimeW-1:0]    span_us_q;
	logic [asesq_pkg::TimeW-1:0]    base_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prober_type_q <= asesq_pkg::RstProberType;
			mask_q <= asesq_pkg::RstMask;
			pre_ms_q <= asesq_pkg::RstPreMs;
			post_ms_q <= asesq_pkg::RstPostMs;
			step_ms_q <= asesq_pkg::RstStepMs;
			amp_q <= asesq_pkg::RstAmp;
			stepped_q <= asesq_pkg::RstStepped;
			act_count_q <= asesq_pkg::RstActCount;
			pre_us_q <= asesq_pkg::ms_to_us(asesq_pkg::RstPreMs);
			post_us_q <= asesq_pkg::ms_to_us(asesq_pkg::RstPostMs);
			step_us_q <= asesq_pkg::ms_to_us(asesq_pkg::RstStepMs);
			span_us_q <= asesq_pkg::span_us(asesq_pkg::RstStepMs, asesq_pkg::RstStepped);
			base_us_q <= asesq_pkg::base_us(asesq_pkg::RstPreMs, asesq_pkg::RstPostMs);
		end else if (cfg_we) begin
			case (asesq_pkg::reg_idx_t'(cfg_idx))
				asesq_pkg::REG_PROBER_TYPE: prober_type_q <= cfg_wdata[1:0];
				asesq_pkg::REG_ACT_MASK: mask_q <= cfg_wdata;
				asesq_pkg::REG_PRE_DELAY: begin
					pre_ms_q <= cfg_wdata;
					pre_us_q <= asesq_pkg::ms_to_us(cfg_wdata);
					base_us_q <= asesq_pkg::base_us(cfg_wdata, post_ms_q);
				end
				asesq_pkg::REG_POST_DELAY: begin
					post_ms_q <= cfg_wdata;
					post_us_q <= asesq_pkg::ms_to_us(cfg_wdata);
					base_us_q <= asesq_pkg::base_us(pre_ms_q, cfg_wdata);
				end
				asesq_pkg::REG_STEP_PERIOD: begin
					step_ms_q <= cfg_wdata;
					step_us_q <= asesq_pkg::ms_to_us(cfg_wdata);
					span_us_q <= asesq_pkg::span_us(cfg_wdata, stepped_q);
				end
				asesq_pkg::REG_STEP_AMP: amp_q <= cfg_wdata[asesq_pkg::DriveW-1:0];
				asesq_pkg::REG_STEPPED: begin
					stepped_q <= cfg_wdata[asesq_pkg::IdxW-1:0];
					span_us_q <= asesq_pkg::span_us(step_ms_q,
						cfg_wdata[asesq_pkg::IdxW-1:0]);
				end
				asesq_pkg::REG_ACT_COUNT: act_count_q <= cfg_wdata[asesq_pkg::IdxW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.prober_type = prober_type_q;
	assign cfg.mask = mask_q;
	assign cfg.pre_us = pre_us_q;
	assign cfg.post_us = post_us_q;
	assign cfg.step_us = step_us_q;
	assign cfg.span_us = span_us_q;
	assign cfg.base_us = base_us_q;
	assign cfg.amp = amp_q;
	assign cfg.stepped = stepped_q;
	assign cfg.act_count = act_count_q;

endmodule

// ===== rtl/asesq_core.sv =====
// Sequencer state and the single-pass update for start and periodic items.
module asesq_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asesq_pkg::cfg_t               cfg,
	input  logic                          fire,
	input  logic                          mode,
	input  logic [asesq_pkg::TimeW-1:0]   now,
	output asesq_pkg::result_t            res
);

	localparam int DW = asesq_pkg::DriveW;
	localparam int TW = asesq_pkg::TimeW;
	localparam int IW = asesq_pkg::IdxW;
	localparam int MW = asesq_pkg::MaskW;

	logic          armed_q, gen_done_q, run_done_q, running_q;
	logic [TW-1:0] start_q, finish_q, deadline_q, next_step_q;
	logic [IW-1:0] step_idx_q;
	logic [DW-1:0] drv_q [4];

	logic          armed_d, gen_done_d, run_done_d, running_d;
	logic [TW-1:0] start_d, finish_d, deadline_d, next_step_d;
	logic [IW-1:0] step_idx_d;
	logic [DW-1:0] drv_d [4];

	logic [TW-1:0] d_start, d_finish, d_deadline;
	logic          in_pre, post_over, dl_over;
	logic [MW-1:0] eff;
	logic [IW-1:0] total;
	logic          found;
	logic [3:0]    hit;
	logic          tgt_v;
	logic [1:0]    tgt;
	logic [IW-1:0] fallback;
	logic [DW-1:0] amp;
	logic [TW-1:0] adj;

	assign d_start = now - start_q;
	assign d_finish = now - finish_q;
	assign d_deadline = now - deadline_q;
	assign in_pre = $signed(d_start) <= $signed(cfg.pre_us);
	assign post_over = $signed(d_finish) > $signed(cfg.post_us);
	assign dl_over = !d_deadline[TW-1] && (d_deadline != '0);
	assign amp = (cfg.amp > asesq_pkg::AmpMax) ? asesq_pkg::AmpMax : cfg.amp;
	assign fallback = cfg.act_count - IW'(1);

	always_comb begin
		for (int p = 0; p < MW; p++) begin
			eff[p] = cfg.mask[p] && (IW'(p) < cfg.act_count);
		end
		total = IW'($countones(eff));
		found = step_idx_q < total;
		for (int p = 0; p < 4; p++) begin
			hit[p] = eff[p] &&
				(IW'($countones(eff & ((MW'(1) << p) - MW'(1)))) == step_idx_q);
		end
		tgt_v = 1'b0;
		tgt = 2'd0;
		if (found) begin
			tgt_v = |hit;
			if (hit[0]) tgt = 2'd0;
			else if (hit[1]) tgt = 2'd1;
			else if (hit[2]) tgt = 2'd2;
			else tgt = 2'd3;
		end else begin
			tgt_v = fallback < IW'(4);
			tgt = fallback[1:0];
		end
	end

	always_comb begin
		case (cfg.prober_type)
			asesq_pkg::PT_STEP: adj = cfg.span_us;
			asesq_pkg::PT_ORTHO: adj = asesq_pkg::OrthoUs;
			default: adj = '0;
		endcase
	end

	always_comb begin
		armed_d = armed_q;
		gen_done_d = gen_done_q;
		run_done_d = run_done_q;
		running_d = running_q;
		start_d = start_q;
		finish_d = finish_q;
		deadline_d = deadline_q;
		next_step_d = next_step_q;
		step_idx_d = step_idx_q;
		for (int i = 0; i < 4; i++) drv_d[i] = drv_q[i];
		if (!mode) begin
			start_d = now;
			deadline_d = now + cfg.base_us + adj;
			if (cfg.prober_type == asesq_pkg::PT_STEP) begin
				step_idx_d = '0;
				next_step_d = now + cfg.pre_us + cfg.step_us;
			end
			armed_d = 1'b1;
			gen_done_d = 1'b0;
			run_done_d = 1'b0;
			for (int i = 0; i < 4; i++) drv_d[i] = '0;
		end else if (!armed_q || in_pre || gen_done_q || run_done_q) begin
			for (int i = 0; i < 4; i++) drv_d[i] = '0;
			if (gen_done_q && post_over) begin
				run_done_d = 1'b1;
				armed_d = 1'b0;
				running_d = 1'b0;
			end else begin
				running_d = gen_done_q;
			end
		end else if (dl_over) begin
			run_done_d = 1'b1;
			armed_d = 1'b0;
			running_d = 1'b0;
			for (int i = 0; i < 4; i++) drv_d[i] = '0;
		end else begin
			running_d = 1'b1;
			if (cfg.prober_type == asesq_pkg::PT_STEP) begin
				for (int i = 0; i < 4; i++) drv_d[i] = '0;
				if (step_idx_q < cfg.stepped) begin
					if (tgt_v) begin
						case (tgt)
							2'd0: drv_d[0] = amp;
							2'd1: begin
								drv_d[1] = amp;
								drv_d[2] = asesq_pkg::ServoTrig;
							end
							2'd2: begin
								drv_d[0] = amp;
								drv_d[3] = asesq_pkg::ServoTrig;
							end
							default: drv_d[1] = amp;
						endcase
					end
					if (now >= next_step_q) begin
						step_idx_d = step_idx_q + IW'(1);
						next_step_d = next_step_q + cfg.step_us;
					end
				end else begin
					gen_done_d = 1'b1;
					finish_d = now;
				end
			end else if (cfg.prober_type == asesq_pkg::PT_ORTHO) begin
				for (int i = 0; i < 4; i++) drv_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			gen_done_q <= 1'b0;
			run_done_q <= 1'b0;
			running_q <= 1'b0;
			start_q <= '0;
			finish_q <= '0;
			deadline_q <= '0;
			next_step_q <= '0;
			step_idx_q <= '0;
			for (int i = 0; i < 4; i++) drv_q[i] <= '0;
		end else if (fire) begin
			armed_q <= armed_d;
			gen_done_q <= gen_done_d;
			run_done_q <= run_done_d;
			running_q <= running_d;
			start_q <= start_d;
			finish_q <= finish_d;
			deadline_q <= deadline_d;
			next_step_q <= next_step_d;
			step_idx_q <= step_idx_d;
			for (int i = 0; i < 4; i++) drv_q[i] <= drv_d[i];
		end
	end

	assign res.drive_0 = drv_d[0];
	assign res.drive_1 = drv_d[1];
	assign res.drive_2 = drv_d[2];
	assign res.drive_3 = drv_d[3];
	assign res.generating = running_d;
	assign res.generation_done = gen_done_d;
	assign res.all_done = run_done_d;

endmodule

// ===== rtl/asesq_obuf.sv =====
// Result register with a skid stage so one further input transfer is taken while the output stalls.
module asesq_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  asesq_pkg::result_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output asesq_pkg::result_t out_data
);

	logic               out_v_q, skid_v_q;
	asesq_pkg::result_t out_q, skid_q;
	logic               in_fire;

	assign in_ready = !skid_v_q;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (skid_v_q) out_q <= skid_q;
			else if (in_fire) out_q <= in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;

endmodule

// ===== rtl/actuator_step_excitation_sequencer_core.sv =====
// Top level of the actuator step-excitation sequencer.
// Results are registered in the output buffer, or in its skid entry while it stalls.
// Throughput: one item per cycle while s_tready is high; the state update and the
// result are one registered pass. s_tready drops once the two-entry buffer is full.
// Reset (arst_n low, asynchronous): sequencer disarmed, flags and drives cleared,
// configuration back to its defaults, output buffer empty.
module actuator_step_excitation_sequencer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [asesq_pkg::CfgW-1:0]  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // now_us
	input  logic                        s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// drive_0, drive_1, drive_2, drive_3, generating, generation_done, all_done, pad
	output logic [31:0]                 m_tdata
);

	asesq_pkg::cfg_t    cfg;
	asesq_pkg::result_t res, res_out;
	logic               fire;

	assign fire = s_tvalid && s_tready;

	asesq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	asesq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.mode   (s_tuser),
		.now    (s_tdata),
		.res    (res)
	);

	asesq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tdata = {1'b0, res_out};

endmodule
